FILE: rtl/lru_key_value_cache_core_assert.svh
// assertion macros for the lru key-value cache core
// macros expect clk and rst_n in scope of the including module
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// condition holds at every rising clock edge outside reset
`define LKVC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent, consequent may be a delayed sequence
`define LKVC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

FILE: rtl/lru_kvc_pkg.sv
// shared constants for the lru key-value cache core
// no dependencies
package lru_kvc_pkg;

    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int DEF_ENTRIES = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic              OP_GET    = 1'b0;
    localparam logic              OP_PUT    = 1'b1;
    localparam logic [DATA_W-1:0] READ_MISS = 32'hFFFF_FFFF;

endpackage

FILE: rtl/lru_kvc_select.sv
// parallel key match, victim and free entry selection
// depends on lru_kvc_pkg
module lru_kvc_select
    import lru_kvc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic [ENTRIES-1:0]                                   valid,
    input  logic [KEY_W-1:0]                                     entry_key [ENTRIES],
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]     entry_rank [ENTRIES],
    input  logic [KEY_W-1:0]                                     key,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]     victim_rank,
    output logic                                                 hit,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]     hit_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]     victim_idx,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]     free_idx
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] oldest;

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid[i] && (entry_key[i] == key);
            oldest[i] = valid[i] && (entry_rank[i] == victim_rank);
        end
    end

    assign hit = |match;

    // lowest index wins on every encoder
    always_comb
    begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (oldest[i])
            begin
                victim_idx = IDX_W'(i);
            end
            if (!valid[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/lru_key_value_cache_core.sv
// lru key-value cache core: start transfer is registered, then the result register raises the done strobe
// throughput one request per cycle, busy stays low, the receiver cannot stall
// stage 1 registers the request, stage 2 does match, update and result in one pass
// reset clears valid bits, occupancy and pipeline strobes, capacity returns to 16
// depends on lru_kvc_pkg, lru_kvc_select and the assertion macro header
`include "lru_key_value_cache_core_assert.svh"
module lru_key_value_cache_core
    import lru_kvc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration: capacity register
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    // request side
    input  logic                     start,
    output logic                     busy,
    input  logic                     opcode,
    input  logic signed [KEY_W-1:0]  key,
    input  logic signed [DATA_W-1:0] value,
    // result side
    output logic                     done,
    output logic                     hit,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     evicted,
    output logic signed [KEY_W-1:0]  evicted_key
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // capacity register
    logic [CAP_W-1:0]  cap_reg;

    // request register
    logic              in_vld_reg;
    logic              in_op_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic [DATA_W-1:0] in_value_reg;

    // entry store, valid bits and occupancy reset, payload written before use
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    logic [DATA_W-1:0]  value_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];

    // result register
    logic              done_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;
    logic [KEY_W-1:0]  evicted_key_reg;

    // lookup results
    logic             sel_hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] victim_idx;
    logic [IDX_W-1:0] free_idx;
    logic [OCC_W-1:0] occ_m1;
    logic [IDX_W-1:0] victim_rank;
    logic [IDX_W-1:0] hit_rank;

    // decision signals
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic             full;
    logic             is_put;
    logic             do_evict;
    logic             do_fill;
    logic             upd_en;
    logic [IDX_W-1:0] slot;

    // no clearing pass and no multi-cycle work, so requests are never held off
    assign busy = 1'b0;

    // the oldest valid entry always carries rank occupancy - 1
    assign occ_m1      = occ_reg - OCC_W'(1);
    assign victim_rank = occ_m1[IDX_W-1:0];

    lru_kvc_select #(
        .ENTRIES (ENTRIES)
    ) u_select (
        .valid       (valid_reg),
        .entry_key   (key_reg),
        .entry_rank  (rank_reg),
        .key         (in_key_reg),
        .victim_rank (victim_rank),
        .hit         (sel_hit),
        .hit_idx     (hit_idx),
        .victim_idx  (victim_idx),
        .free_idx    (free_idx)
    );

    assign hit_rank = rank_reg[hit_idx];

    // effective capacity: zero counts as one, anything above the store size is clipped
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign full     = CMP_W'(occ_reg) >= eff_cap;
    assign is_put   = (in_op_reg == OP_PUT);
    assign do_evict = in_vld_reg && is_put && !sel_hit && full;
    assign do_fill  = in_vld_reg && is_put && !sel_hit && !full;
    assign upd_en   = in_vld_reg && (sel_hit || is_put);

    // target entry: the hit, the victim on a full store, or the lowest free slot
    always_comb
    begin
        if (sel_hit)
        begin
            slot = hit_idx;
        end
        else if (full)
        begin
            slot = victim_idx;
        end
        else
        begin
            slot = free_idx;
        end
    end

    // recency update: target goes to rank zero, newer entries age by one;
    // on a miss every valid entry ages (the victim already holds the top rank)
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (IDX_W'(i) == slot)
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (!sel_hit || (rank_reg[i] < hit_rank)))
            begin
                rank_next[i] = rank_reg[i] + IDX_W'(1);
            end
            else
            begin
                rank_next[i] = rank_reg[i];
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        if (do_fill)
        begin
            valid_next[slot] = 1'b1;
            occ_next         = occ_reg + OCC_W'(1);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            in_vld_reg <= 1'b0;
            valid_reg  <= '0;
            occ_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            in_vld_reg <= start && !busy;
            valid_reg  <= valid_next;
            occ_reg    <= occ_next;
            done_reg   <= in_vld_reg;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_op_reg    <= opcode;
            in_key_reg   <= key;
            in_value_reg <= value;
        end
    end

    // entry payload and ranks
    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (is_put)
            begin
                value_reg[slot] <= in_value_reg;
            end
            if (!sel_hit)
            begin
                key_reg[slot] <= in_key_reg;
            end
        end
    end

    // result register, valid for one cycle under done
    always_ff @(posedge clk)
    begin
        if (in_vld_reg)
        begin
            hit_reg     <= sel_hit;
            evicted_reg <= do_evict;
            if (is_put)
            begin
                read_value_reg <= '0;
            end
            else if (sel_hit)
            begin
                read_value_reg <= value_reg[hit_idx];
            end
            else
            begin
                read_value_reg <= READ_MISS;
            end
            evicted_key_reg <= do_evict ? key_reg[victim_idx] : '0;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // occupancy tracks the valid bits
    `LKVC_ASSERT_ALWAYS(a_occ_count, $countones(valid_reg) == occ_reg, "occupancy mismatch")
    // every start transfer yields a done strobe, after the request and result registers
    `LKVC_ASSERT_IMPLIES(a_latency, start && !busy, ##2 done_reg, "result strobe missing")
    // a reported eviction is always a put miss
    `LKVC_ASSERT_IMPLIES(a_evict_miss, done_reg && evicted_reg, !hit_reg, "eviction on a hit")
    // eviction only happens once the store holds entries
    `LKVC_ASSERT_IMPLIES(a_evict_nonempty, do_evict, occ_reg != '0, "eviction from empty store")

endmodule
